FILE: hw/rtl/rcr_pkg.sv
`timescale 1ns / 1ps

package rcr_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_HEADER = 2'd1;
    localparam logic [1:0] CMD_PIXEL  = 2'd2;

    // Configuration register indexes
    localparam int          CFG_INDEX_W      = 1;
    localparam logic [0:0]  REG_MAC_PREFIX   = 1'd0;
    localparam logic [0:0]  REG_FIRST_WORKER = 1'd1;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int MAC_W      = 48;
    localparam int PREFIX_W   = 40;
    localparam int CFG_DATA_W = 40;
    localparam int CHUNK_W    = 32;
    localparam int PIXEL_W    = 8;
    localparam int ADDR_W     = 17;
    localparam int WIDX_OUT_W = 2;
    localparam int DONE_OUT_W = 7;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 40;

    // Register reset values
    localparam logic [PREFIX_W-1:0] RST_MAC_PREFIX   = 40'h02B4B40000;
    localparam logic [7:0]          RST_FIRST_WORKER = 8'h02;

    // Default geometry
    localparam int DEF_WORKERS       = 4;
    localparam int DEF_WORKER_CHUNKS = 19;
    localparam int DEF_CHUNK_PIXELS  = 1020;
    localparam int DEF_WORKER_PIXELS = 19200;
    localparam int DEF_FRAME_PIXELS  = 76800;

    // Header decode results handed from the decode stage to the tracker
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             mac_ok;   // MAC names a worker
        logic             hdr_ok;   // result header for an in-range chunk
    } rcr_flags_t;

endpackage

FILE: hw/rtl/rcr_decode.sv
`timescale 1ns / 1ps

module rcr_decode import rcr_pkg::*; #(
    parameter int WORKERS       = DEF_WORKERS,
    parameter int WORKER_CHUNKS = DEF_WORKER_CHUNKS,
    parameter int CHUNK_PIXELS  = DEF_CHUNK_PIXELS,
    parameter int WORKER_PIXELS = DEF_WORKER_PIXELS,
    parameter int FRAME_PIXELS  = DEF_FRAME_PIXELS,
    localparam int TOTAL    = WORKERS * WORKER_CHUNKS,
    localparam int WORKER_W = (WORKERS > 1) ? $clog2(WORKERS) : 1,
    localparam int MAP_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1,
    localparam int PTR_W    = $clog2(FRAME_PIXELS + 1),
    localparam int OFF_MAX  = (WORKERS - 1) * WORKER_PIXELS + (TOTAL - 1) * CHUNK_PIXELS,
    localparam int OFF_W    = ($clog2(OFF_MAX + 1) > PTR_W) ? $clog2(OFF_MAX + 1) : PTR_W
) (
    input  logic                clk,
    input  logic                rst_n,
    // incoming item
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [MAC_W-1:0]    src_mac,
    input  logic                is_result,
    input  logic                header_complete,
    input  logic [CHUNK_W-1:0]  chunk_num,
    input  logic [PIXEL_W-1:0]  pixel_value,
    // configuration
    input  logic [PREFIX_W-1:0] mac_prefix,
    input  logic [7:0]          first_worker,
    // decoded item towards the tracker
    input  logic                adv,
    output logic                st_valid,
    output rcr_flags_t          st_flags,
    output logic [WORKER_W-1:0] st_worker,
    output logic [MAP_W-1:0]    st_gidx,
    output logic [OFF_W-1:0]    st_offset,
    output logic [PIXEL_W-1:0]  st_pixel
);

    localparam int G_W = $clog2(2 * TOTAL);

    logic                st_valid_reg, st_valid_next;
    rcr_flags_t          flags_reg, flags_next;
    logic [WORKER_W-1:0] worker_reg;
    logic [MAP_W-1:0]    gidx_reg;
    logic [OFF_W-1:0]    offset_reg, offset_next;
    logic [PIXEL_W-1:0]  pixel_reg;

    logic [7:0]          worker8;
    logic [WORKER_W-1:0] wsel;
    logic [G_W-1:0]      chunk_g;
    logic [G_W-1:0]      gnum;
    logic                chunk_small;
    logic                load;

    assign in_ready = !st_valid_reg || adv;
    assign load     = in_valid && in_ready;

    // Worker number from the MAC low byte, wrapping mod 256
    assign worker8 = src_mac[7:0] - first_worker;
    assign wsel    = worker8[WORKER_W-1:0];

    // Global chunk number; only meaningful when the index is already in range
    assign chunk_small = chunk_num < CHUNK_W'(TOTAL);
    assign chunk_g     = chunk_num[G_W-1:0];
    assign gnum        = G_W'(wsel) * G_W'(WORKER_CHUNKS) + chunk_g;

    always_comb
    begin
        flags_next.cmd    = cmd;
        flags_next.mac_ok = (src_mac[MAC_W-1:8] == mac_prefix) && (worker8 < 8'(WORKERS));
        flags_next.hdr_ok = flags_next.mac_ok && is_result && header_complete
                            && chunk_small && (gnum < G_W'(TOTAL));
        // frame offset of the chunk, clamped later in the tracker
        offset_next = OFF_W'(wsel) * OFF_W'(WORKER_PIXELS)
                    + OFF_W'(chunk_g) * OFF_W'(CHUNK_PIXELS);
    end

    // Stage occupancy
    always_comb
    begin
        if (load)
            st_valid_next = 1'b1;
        else if (adv)
            st_valid_next = 1'b0;
        else
            st_valid_next = st_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= st_valid_next;
    end

    // Decoded payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg  <= flags_next;
            worker_reg <= wsel;
            gidx_reg   <= gnum[MAP_W-1:0];
            offset_reg <= offset_next;
            pixel_reg  <= pixel_value;
        end
    end

    assign st_valid  = st_valid_reg;
    assign st_flags  = flags_reg;
    assign st_worker = worker_reg;
    assign st_gidx   = gidx_reg;
    assign st_offset = offset_reg;
    assign st_pixel  = pixel_reg;

endmodule

FILE: hw/rtl/rcr_track.sv
`timescale 1ns / 1ps

module rcr_track import rcr_pkg::*; #(
    parameter int WORKERS       = DEF_WORKERS,
    parameter int WORKER_CHUNKS = DEF_WORKER_CHUNKS,
    parameter int CHUNK_PIXELS  = DEF_CHUNK_PIXELS,
    parameter int WORKER_PIXELS = DEF_WORKER_PIXELS,
    parameter int FRAME_PIXELS  = DEF_FRAME_PIXELS,
    localparam int TOTAL    = WORKERS * WORKER_CHUNKS,
    localparam int WORKER_W = (WORKERS > 1) ? $clog2(WORKERS) : 1,
    localparam int MAP_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1,
    localparam int PTR_W    = $clog2(FRAME_PIXELS + 1),
    localparam int OFF_MAX  = (WORKERS - 1) * WORKER_PIXELS + (TOTAL - 1) * CHUNK_PIXELS,
    localparam int OFF_W    = ($clog2(OFF_MAX + 1) > PTR_W) ? $clog2(OFF_MAX + 1) : PTR_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // decoded item
    input  logic                  st_valid,
    output logic                  adv,
    input  rcr_flags_t            st_flags,
    input  logic [WORKER_W-1:0]   st_worker,
    input  logic [MAP_W-1:0]      st_gidx,
    input  logic [OFF_W-1:0]      st_offset,
    input  logic [PIXEL_W-1:0]    st_pixel,
    // result
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  write_valid,
    output logic [ADDR_W-1:0]     write_address,
    output logic [PIXEL_W-1:0]    write_value,
    output logic                  chunk_accepted,
    output logic [WIDX_OUT_W-1:0] worker_index,
    output logic [DONE_OUT_W-1:0] chunks_done,
    output logic                  all_done
);

    localparam int CNT_W = $clog2(TOTAL + 1);

    logic [TOTAL-1:0]      map_reg, map_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  accepting_reg, accepting_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;

    logic                  out_valid_reg;
    logic                  wv_reg, wv_next;
    logic [ADDR_W-1:0]     wa_reg, wa_next;
    logic [PIXEL_W-1:0]    wval_reg, wval_next;
    logic                  acc_reg, acc_next;
    logic [WIDX_OUT_W-1:0] widx_reg, widx_next;
    logic [DONE_OUT_W-1:0] done_reg;
    logic                  all_reg;

    logic                  take;
    logic [PTR_W-1:0]      ptr_load;

    assign adv  = !out_valid_reg || out_ready;
    assign take = st_valid && adv;

    // Chunk start address, stopped at the frame end
    assign ptr_load = (st_offset < OFF_W'(FRAME_PIXELS)) ? PTR_W'(st_offset)
                                                         : PTR_W'(FRAME_PIXELS);

    // Collection state update for one word
    always_comb
    begin
        map_next       = map_reg;
        count_next     = count_reg;
        accepting_next = accepting_reg;
        ptr_next       = ptr_reg;
        wv_next        = 1'b0;
        wa_next        = '0;
        wval_next      = '0;
        acc_next       = 1'b0;
        widx_next      = '0;
        case (st_flags.cmd)
            CMD_CLEAR:
            begin
                map_next       = '0;
                count_next     = '0;
                accepting_next = 1'b0;
            end
            CMD_HEADER:
            begin
                accepting_next = 1'b0;
                if (st_flags.mac_ok)
                    widx_next = WIDX_OUT_W'(st_worker);
                if (st_flags.hdr_ok && !map_reg[st_gidx])
                begin
                    map_next[st_gidx] = 1'b1;
                    count_next        = count_reg + CNT_W'(1);
                    accepting_next    = 1'b1;
                    acc_next          = 1'b1;
                    ptr_next          = ptr_load;
                end
            end
            CMD_PIXEL:
            begin
                if (accepting_reg && (ptr_reg < PTR_W'(FRAME_PIXELS)))
                begin
                    wv_next   = 1'b1;
                    wa_next   = ADDR_W'(ptr_reg);
                    wval_next = st_pixel;
                    ptr_next  = ptr_reg + PTR_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Collection state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg       <= '0;
            count_reg     <= '0;
            accepting_reg <= 1'b0;
            ptr_reg       <= '0;
        end
        else if (take)
        begin
            map_reg       <= map_next;
            count_reg     <= count_next;
            accepting_reg <= accepting_next;
            ptr_reg       <= ptr_next;
        end
    end

    // Result register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= st_valid;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            wv_reg   <= wv_next;
            wa_reg   <= wa_next;
            wval_reg <= wval_next;
            acc_reg  <= acc_next;
            widx_reg <= widx_next;
            done_reg <= DONE_OUT_W'(count_next);
            all_reg  <= (count_next >= CNT_W'(TOTAL));
        end
    end

    assign out_valid      = out_valid_reg;
    assign write_valid    = wv_reg;
    assign write_address  = wa_reg;
    assign write_value    = wval_reg;
    assign chunk_accepted = acc_reg;
    assign worker_index   = widx_reg;
    assign chunks_done    = done_reg;
    assign all_done       = all_reg;

endmodule

FILE: hw/rtl/result_chunk_reassembler.sv
`timescale 1ns / 1ps

// Result chunk reassembler.
// Input stream (s_*): one word per item. s_tuser holds the item kind (clear,
// packet header, pixel byte); s_tdata holds the sender MAC, the result and
// header-complete flags, the chunk number and the pixel byte.
// Output stream (m_*): exactly one word per input word, carrying the frame
// write (valid, address, byte), the chunk-accepted flag, the worker index,
// the count of chunks received and the all-done flag.
// Configuration: cfg_we/cfg_index/cfg_wdata write the MAC prefix (index 0)
// and the MAC low byte of worker zero (index 1); write only while idle.
// Pipeline: input register, then result register, which drives m_tdata.
// Throughput: one word per cycle while m_tready is high; the received-chunk
// bitmap is held in flops and the combinational header check with its
// offset add sets the clock.
// Reset clears the bitmap, the count, the accept flag and the write pointer
// and loads the register defaults; both stream sides come up empty.
// When m_tready is low the result register holds its word, the input stage
// still takes one more word, and s_tready then drops until the output moves.

module result_chunk_reassembler import rcr_pkg::*; #(
    parameter int WORKERS       = DEF_WORKERS,
    parameter int WORKER_CHUNKS = DEF_WORKER_CHUNKS,
    parameter int CHUNK_PIXELS  = DEF_CHUNK_PIXELS,
    parameter int WORKER_PIXELS = DEF_WORKER_PIXELS,
    parameter int FRAME_PIXELS  = DEF_FRAME_PIXELS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // src_mac[47:0], is_result[48], header_complete[49], chunk_num[81:50],
    // pixel_value[89:82], zero pad[95:90]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]       s_tuser,
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // write_valid[0], write_address[17:1], write_value[25:18],
    // chunk_accepted[26], worker_index[28:27], chunks_done[35:29],
    // all_done[36], zero pad[39:37]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // configuration
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int TOTAL    = WORKERS * WORKER_CHUNKS;
    localparam int WORKER_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int MAP_W    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int PTR_W    = $clog2(FRAME_PIXELS + 1);
    localparam int OFF_MAX  = (WORKERS - 1) * WORKER_PIXELS + (TOTAL - 1) * CHUNK_PIXELS;
    localparam int OFF_W    = ($clog2(OFF_MAX + 1) > PTR_W) ? $clog2(OFF_MAX + 1) : PTR_W;

    logic [PREFIX_W-1:0]   mac_prefix_reg;
    logic [7:0]            first_worker_reg;

    logic                  st_valid;
    logic                  adv;
    rcr_flags_t            st_flags;
    logic [WORKER_W-1:0]   st_worker;
    logic [MAP_W-1:0]      st_gidx;
    logic [OFF_W-1:0]      st_offset;
    logic [PIXEL_W-1:0]    st_pixel;

    logic                  write_valid;
    logic [ADDR_W-1:0]     write_address;
    logic [PIXEL_W-1:0]    write_value;
    logic                  chunk_accepted;
    logic [WIDX_OUT_W-1:0] worker_index;
    logic [DONE_OUT_W-1:0] chunks_done;
    logic                  all_done;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_prefix_reg   <= RST_MAC_PREFIX;
            first_worker_reg <= RST_FIRST_WORKER;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAC_PREFIX:   mac_prefix_reg   <= cfg_wdata[PREFIX_W-1:0];
                REG_FIRST_WORKER: first_worker_reg <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register and header decode
    rcr_decode #(
        .WORKERS       (WORKERS),
        .WORKER_CHUNKS (WORKER_CHUNKS),
        .CHUNK_PIXELS  (CHUNK_PIXELS),
        .WORKER_PIXELS (WORKER_PIXELS),
        .FRAME_PIXELS  (FRAME_PIXELS)
    ) u_decode (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .cmd             (s_tuser),
        .src_mac         (s_tdata[47:0]),
        .is_result       (s_tdata[48]),
        .header_complete (s_tdata[49]),
        .chunk_num       (s_tdata[81:50]),
        .pixel_value     (s_tdata[89:82]),
        .mac_prefix      (mac_prefix_reg),
        .first_worker    (first_worker_reg),
        .adv             (adv),
        .st_valid        (st_valid),
        .st_flags        (st_flags),
        .st_worker       (st_worker),
        .st_gidx         (st_gidx),
        .st_offset       (st_offset),
        .st_pixel        (st_pixel)
    );

    // Bitmap, count, write pointer and result register
    rcr_track #(
        .WORKERS       (WORKERS),
        .WORKER_CHUNKS (WORKER_CHUNKS),
        .CHUNK_PIXELS  (CHUNK_PIXELS),
        .WORKER_PIXELS (WORKER_PIXELS),
        .FRAME_PIXELS  (FRAME_PIXELS)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .st_valid       (st_valid),
        .adv            (adv),
        .st_flags       (st_flags),
        .st_worker      (st_worker),
        .st_gidx        (st_gidx),
        .st_offset      (st_offset),
        .st_pixel       (st_pixel),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .write_valid    (write_valid),
        .write_address  (write_address),
        .write_value    (write_value),
        .chunk_accepted (chunk_accepted),
        .worker_index   (worker_index),
        .chunks_done    (chunks_done),
        .all_done       (all_done)
    );

    // Output word packing
    assign m_tdata = {3'b000, all_done, chunks_done, worker_index, chunk_accepted,
                      write_value, write_address, write_valid};

endmodule
